[hdl/msadpcm_pkg.sv]
package msadpcm_pkg;

	localparam int NUM_CHANNELS = 2;
	localparam int SAMPLE_W = 16;
	localparam int NIBBLE_W = 4;
	localparam int TAB_W = 10;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_DECODE = 2'd1;
	localparam logic [1:0] OP_EMIT = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = -16'sd32768;
	localparam logic signed [SAMPLE_W-1:0] STEP_FLOOR = 16'sd16;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_DECODE,
		KIND_EMIT
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic                        chan;
		logic [NIBBLE_W-1:0]         code_nibble;
		logic signed [SAMPLE_W-1:0]  coef_one;
		logic signed [SAMPLE_W-1:0]  coef_two;
		logic signed [SAMPLE_W-1:0]  initial_step;
		logic signed [SAMPLE_W-1:0]  newer_history;
		logic signed [SAMPLE_W-1:0]  older_history;
		logic                        pick_newer;
	} work_t;

	function automatic logic [TAB_W-1:0] adapt_factor(input logic [NIBBLE_W-1:0] code);
		logic [TAB_W-1:0] f;
		case (code)
			4'd4:    f = 10'd307;
			4'd5:    f = 10'd409;
			4'd6:    f = 10'd512;
			4'd7:    f = 10'd614;
			4'd8:    f = 10'd768;
			4'd9:    f = 10'd614;
			4'd10:   f = 10'd512;
			4'd11:   f = 10'd409;
			4'd12:   f = 10'd307;
			default: f = 10'd230;
		endcase
		return f;
	endfunction

endpackage

[hdl/ms_adpcm_sample_decoder.sv]
// Channel   Handshake                 Payload
// item      item_valid / item_stall   op, chan, code_nibble, coef_one, coef_two,
//                                     initial_step, newer_history, older_history, pick_newer
// sample    pcm_valid / pcm_stall     pcm, out_chan
//
// One item per cycle while unstalled; results pass the input, queue and output registers.
// The decode unit reads and writes the channel state in the same cycle, so a decode
// for a channel may directly follow another for that channel.
// Reset clears all channel state, the queue and both valid flags.
// A stall on the sample side fills the output register, then the two-entry queue,
// then the input register before item_stall rises; header loads still drain.
module ms_adpcm_sample_decoder (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  logic [1:0]                              op,
	input  logic                                    chan,
	input  logic [msadpcm_pkg::NIBBLE_W-1:0]        code_nibble,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] coef_one,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] coef_two,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] initial_step,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] newer_history,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] older_history,
	input  logic                                    pick_newer,
	output logic                                    pcm_valid,
	input  logic                                    pcm_stall,
	output logic signed [msadpcm_pkg::SAMPLE_W-1:0] pcm,
	output logic                                    out_chan
);
	import msadpcm_pkg::*;

	logic  push_valid;
	work_t push_item;
	logic  queue_full;
	logic  pop_valid;
	work_t pop_item;
	logic  pop;

	msadpcm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.chan          (chan),
		.code_nibble   (code_nibble),
		.coef_one      (coef_one),
		.coef_two      (coef_two),
		.initial_step  (initial_step),
		.newer_history (newer_history),
		.older_history (older_history),
		.pick_newer    (pick_newer),
		.push_valid    (push_valid),
		.push_item     (push_item),
		.queue_full    (queue_full)
	);

	msadpcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.queue_full (queue_full),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	msadpcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (pop_valid),
		.work_item  (pop_item),
		.work_pop   (pop),
		.pcm_valid  (pcm_valid),
		.pcm_stall  (pcm_stall),
		.pcm        (pcm),
		.out_chan   (out_chan)
	);

endmodule

[hdl/msadpcm_front.sv]
module msadpcm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          op,
	input  logic                                chan,
	input  logic [msadpcm_pkg::NIBBLE_W-1:0]    code_nibble,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] coef_one,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] coef_two,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] initial_step,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] newer_history,
	input  logic signed [msadpcm_pkg::SAMPLE_W-1:0] older_history,
	input  logic                                pick_newer,
	output logic                                push_valid,
	output msadpcm_pkg::work_t                  push_item,
	input  logic                                queue_full
);
	import msadpcm_pkg::*;

	logic  valid_s1;
	work_t item_s1;
	logic  accept;
	logic  keep;
	kind_t kind;

	always_comb begin
		keep = int'(chan) < NUM_CHANNELS;
		kind = KIND_LOAD;
		case (op)
			OP_LOAD:   kind = KIND_LOAD;
			OP_DECODE: kind = KIND_DECODE;
			OP_EMIT:   kind = KIND_EMIT;
			default:   keep = 1'b0;
		endcase
	end

	assign item_stall = valid_s1 && queue_full;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (!queue_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind <= kind;
			item_s1.chan <= chan;
			item_s1.code_nibble <= code_nibble;
			item_s1.coef_one <= coef_one;
			item_s1.coef_two <= coef_two;
			item_s1.initial_step <= initial_step;
			item_s1.newer_history <= newer_history;
			item_s1.older_history <= older_history;
			item_s1.pick_newer <= pick_newer;
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;

endmodule

[hdl/msadpcm_queue.sv]
module msadpcm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  msadpcm_pkg::work_t push_item,
	output logic               queue_full,
	output logic               pop_valid,
	output msadpcm_pkg::work_t pop_item,
	input  logic               pop
);
	import msadpcm_pkg::*;

	work_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign queue_full = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && !queue_full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hdl/msadpcm_back.sv]
module msadpcm_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    work_valid,
	input  msadpcm_pkg::work_t                      work_item,
	output logic                                    work_pop,
	output logic                                    pcm_valid,
	input  logic                                    pcm_stall,
	output logic signed [msadpcm_pkg::SAMPLE_W-1:0] pcm,
	output logic                                    out_chan
);
	import msadpcm_pkg::*;

	logic signed [SAMPLE_W-1:0] step_q   [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] newer_q  [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] older_q  [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] coef_a_q [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] coef_b_q [NUM_CHANNELS];

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] pcm_q;
	logic                       chan_q;

	logic                       slot_free;
	logic                       fire;
	logic signed [SAMPLE_W-1:0] cur_step;
	logic signed [SAMPLE_W-1:0] cur_newer;
	logic signed [SAMPLE_W-1:0] cur_older;
	logic signed [SAMPLE_W-1:0] cur_a;
	logic signed [SAMPLE_W-1:0] cur_b;
	logic signed [NIBBLE_W-1:0] delta;
	logic signed [31:0]         prod_a;
	logic signed [31:0]         prod_b;
	logic signed [32:0]         pred_sum;
	logic signed [24:0]         pred;
	logic signed [19:0]         dstep;
	logic signed [25:0]         sample;
	logic signed [SAMPLE_W-1:0] sample_clip;
	logic signed [TAB_W:0]      factor;
	logic signed [26:0]         step_prod;
	logic signed [SAMPLE_W-1:0] step_raw;
	logic signed [SAMPLE_W-1:0] step_next;
	logic signed [SAMPLE_W-1:0] emit_val;

	assign cur_step = step_q[work_item.chan];
	assign cur_newer = newer_q[work_item.chan];
	assign cur_older = older_q[work_item.chan];
	assign cur_a = coef_a_q[work_item.chan];
	assign cur_b = coef_b_q[work_item.chan];

	assign delta = $signed(work_item.code_nibble);
	assign prod_a = cur_newer * cur_a;
	assign prod_b = cur_older * cur_b;
	assign pred_sum = 33'(prod_a) + 33'(prod_b);
	assign pred = $signed(pred_sum[32:8]);
	assign dstep = 20'(delta) * 20'(cur_step);
	assign sample = 26'(dstep) + 26'(pred);

	always_comb begin
		if (sample > 26'(PCM_MAX)) begin
			sample_clip = PCM_MAX;
		end else if (sample < 26'(PCM_MIN)) begin
			sample_clip = PCM_MIN;
		end else begin
			sample_clip = sample[SAMPLE_W-1:0];
		end
	end

	assign factor = $signed({1'b0, adapt_factor(work_item.code_nibble)});
	assign step_prod = 27'(factor) * 27'(cur_step);
	assign step_raw = $signed(step_prod[23:8]);
	assign step_next = (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;
	assign emit_val = work_item.pick_newer ? cur_newer : cur_older;

	assign slot_free = !out_valid_q || !pcm_stall;
	assign fire = work_valid && (work_item.kind == KIND_LOAD || slot_free);
	assign work_pop = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				step_q[i] <= '0;
				newer_q[i] <= '0;
				older_q[i] <= '0;
				coef_a_q[i] <= '0;
				coef_b_q[i] <= '0;
			end
		end else if (fire) begin
			case (work_item.kind)
				KIND_LOAD: begin
					coef_a_q[work_item.chan] <= work_item.coef_one;
					coef_b_q[work_item.chan] <= work_item.coef_two;
					step_q[work_item.chan] <= work_item.initial_step;
					newer_q[work_item.chan] <= work_item.newer_history;
					older_q[work_item.chan] <= work_item.older_history;
				end
				KIND_DECODE: begin
					step_q[work_item.chan] <= step_next;
					older_q[work_item.chan] <= cur_newer;
					newer_q[work_item.chan] <= sample_clip;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && work_item.kind != KIND_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (!pcm_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && work_item.kind != KIND_LOAD) begin
			pcm_q <= (work_item.kind == KIND_DECODE) ? sample_clip : emit_val;
			chan_q <= work_item.chan;
		end
	end

	assign pcm_valid = out_valid_q;
	assign pcm = pcm_q;
	assign out_chan = chan_q;

endmodule

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import msadpcm_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_FIRST = 180;
	localparam int CALM_LAST = 280;

	localparam int ADAPT_FACTOR [16] = '{
		230, 230, 230, 230, 307, 409, 512, 614,
		768, 614, 512, 409, 307, 230, 230, 230
	};
	localparam int STD_COEF_A [7] = '{256, 512, 0, 192, 240, 460, 392};
	localparam int STD_COEF_B [7] = '{0, -256, 0, 64, 0, -208, -232};

	typedef struct {
		logic [1:0]         op;
		logic               chan;
		logic [3:0]         code;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic signed [15:0] step;
		logic signed [15:0] newer;
		logic signed [15:0] older;
		logic               pick;
		bit                 typed;
		logic signed [15:0] want;
	} row_t;

	typedef struct {
		logic signed [15:0] pcm;
		logic               chan;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [1:0] op;
	logic chan;
	logic [NIBBLE_W-1:0] code_nibble;
	logic signed [SAMPLE_W-1:0] coef_one;
	logic signed [SAMPLE_W-1:0] coef_two;
	logic signed [SAMPLE_W-1:0] initial_step;
	logic signed [SAMPLE_W-1:0] newer_history;
	logic signed [SAMPLE_W-1:0] older_history;
	logic pick_newer;
	logic pcm_valid;
	logic pcm_stall;
	logic signed [SAMPLE_W-1:0] pcm;
	logic out_chan;

	logic row_typed;
	logic signed [15:0] row_want;

	bit calm;
	int items_sent;
	int mismatches;
	sample_t expected_samples[$];

	logic signed [15:0] ch_step [2];
	logic signed [15:0] ch_newer [2];
	logic signed [15:0] ch_older [2];
	logic signed [15:0] ch_coef_a [2];
	logic signed [15:0] ch_coef_b [2];

	ms_adpcm_sample_decoder DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("ms_adpcm_sample_decoder regression: fail");
		$finish;
	end

	function automatic void predict_sample(input row_t r, output bit produced,
			output logic signed [15:0] value);
		longint delta;
		longint pred;
		longint total;
		longint scaled;
		logic signed [15:0] next_step;
		produced = 1'b0;
		value = '0;
		case (r.op)
			OP_LOAD: begin
				ch_coef_a[r.chan] = r.c1;
				ch_coef_b[r.chan] = r.c2;
				ch_step[r.chan] = r.step;
				ch_newer[r.chan] = r.newer;
				ch_older[r.chan] = r.older;
			end
			OP_DECODE: begin
				delta = r.code[3] ? longint'(r.code) - 16 : longint'(r.code);
				pred = (longint'(ch_newer[r.chan]) * longint'(ch_coef_a[r.chan]) +
					longint'(ch_older[r.chan]) * longint'(ch_coef_b[r.chan])) >>> 8;
				total = delta * longint'(ch_step[r.chan]) + pred;
				if (total > PCM_MAX)
					total = PCM_MAX;
				else if (total < PCM_MIN)
					total = PCM_MIN;
				scaled = (longint'(ADAPT_FACTOR[r.code]) * longint'(ch_step[r.chan])) >>> 8;
				next_step = scaled[15:0];
				if (next_step < STEP_FLOOR)
					next_step = STEP_FLOOR;
				ch_step[r.chan] = next_step;
				ch_older[r.chan] = ch_newer[r.chan];
				ch_newer[r.chan] = total[15:0];
				value = total[15:0];
				produced = 1'b1;
			end
			OP_EMIT: begin
				value = r.pick ? ch_newer[r.chan] : ch_older[r.chan];
				produced = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input sample_t want,
			input sample_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected pcm=%0d chan=%0d, got pcm=%0d chan=%0d",
				what, want.pcm, want.chan, got.pcm, got.chan);
	endfunction

	always @(posedge clk) begin
		sample_t got;
		sample_t want;
		row_t cur;
		bit produced;
		logic signed [15:0] value;
		if (arst_n) begin
			if (pcm_valid && !pcm_stall) begin
				got.pcm = pcm;
				got.chan = out_chan;
				if (expected_samples.size() == 0) begin
					want.pcm = '0;
					want.chan = 1'b0;
					note_mismatch("no sample pending", want, got);
				end else begin
					want = expected_samples.pop_front();
					if (want.pcm !== got.pcm || want.chan !== got.chan)
						note_mismatch("sample", want, got);
				end
			end
			if (item_valid && !item_stall) begin
				cur.op = op;
				cur.chan = chan;
				cur.code = code_nibble;
				cur.c1 = coef_one;
				cur.c2 = coef_two;
				cur.step = initial_step;
				cur.newer = newer_history;
				cur.older = older_history;
				cur.pick = pick_newer;
				predict_sample(cur, produced, value);
				if (produced) begin
					want.pcm = row_typed ? row_want : value;
					want.chan = chan;
					expected_samples.push_back(want);
				end
			end
		end
	end

	always @(negedge clk) begin
		pcm_stall <= !calm && ($urandom_range(99) < 32);
	end

	function automatic row_t make_row(logic [1:0] r_op, logic r_chan, logic [3:0] r_code,
			int r_c1, int r_c2, int r_step, int r_newer, int r_older, logic r_pick,
			bit r_typed, int r_want);
		row_t r;
		r.op = r_op;
		r.chan = r_chan;
		r.code = r_code;
		r.c1 = 16'(r_c1);
		r.c2 = 16'(r_c2);
		r.step = 16'(r_step);
		r.newer = 16'(r_newer);
		r.older = 16'(r_older);
		r.pick = r_pick;
		r.typed = r_typed;
		r.want = 16'(r_want);
		return r;
	endfunction

	function automatic row_t random_row(logic [1:0] r_op, logic r_chan);
		row_t r;
		r.op = r_op;
		r.chan = r_chan;
		r.code = 4'($urandom_range(15));
		r.c1 = 16'($urandom);
		r.c2 = 16'($urandom);
		r.step = 16'($urandom);
		r.newer = 16'($urandom);
		r.older = 16'($urandom);
		r.pick = 1'($urandom_range(1));
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	task automatic drive_item(input row_t r);
		calm = items_sent >= CALM_FIRST && items_sent < CALM_LAST;
		while (!calm && $urandom_range(99) < 32) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		op <= r.op;
		chan <= r.chan;
		code_nibble <= r.code;
		coef_one <= r.c1;
		coef_two <= r.c2;
		initial_step <= r.step;
		newer_history <= r.newer;
		older_history <= r.older;
		pick_newer <= r.pick;
		row_typed <= r.typed;
		row_want <= r.want;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (r.op != OP_IGNORED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_block();
		row_t r;
		logic ch;
		int idx;
		int count;
		ch = 1'($urandom_range(1));
		r = random_row(OP_LOAD, ch);
		if ($urandom_range(99) < 85) begin
			idx = $urandom_range(6);
			r.c1 = 16'(STD_COEF_A[idx]);
			r.c2 = 16'(STD_COEF_B[idx]);
			r.step = 16'($urandom_range(16, 1024));
		end
		drive_item(r);
		drive_item(make_row(OP_EMIT, ch, 4'd0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		drive_item(make_row(OP_EMIT, ch, 4'd0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0));
		count = $urandom_range(4, 24);
		repeat (count) begin
			if ($urandom_range(99) < 15)
				drive_item(random_row($urandom_range(1) ? OP_DECODE : OP_EMIT, !ch));
			else
				drive_item(random_row(OP_DECODE, ch));
		end
	endtask

	initial begin
		row_t rows[$];
		arst_n = 1'b0;
		item_valid = 1'b0;
		op = OP_LOAD;
		chan = 1'b0;
		code_nibble = '0;
		coef_one = '0;
		coef_two = '0;
		initial_step = '0;
		newer_history = '0;
		older_history = '0;
		pick_newer = 1'b0;
		pcm_stall = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		calm = 1'b0;
		items_sent = 0;
		mismatches = 0;
		for (int c = 0; c < 2; c++) begin
			ch_step[c] = '0;
			ch_newer[c] = '0;
			ch_older[c] = '0;
			ch_coef_a[c] = '0;
			ch_coef_b[c] = '0;
		end

		rows.push_back(make_row(OP_EMIT, 1'b0, 4'd0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0));
		rows.push_back(make_row(OP_EMIT, 1'b1, 4'd0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0));
		rows.push_back(make_row(OP_DECODE, 1'b0, 4'd7, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0));
		rows.push_back(make_row(OP_IGNORED, 1'b1, 4'd5, 100, 200, 300, 400, 500, 1'b1,
			1'b0, 0));
		rows.push_back(make_row(OP_LOAD, 1'b0, 4'd0, 256, 0, 16, 32767, -32768, 1'b0,
			1'b0, 0));
		rows.push_back(make_row(OP_EMIT, 1'b0, 4'd0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 32767));
		rows.push_back(make_row(OP_EMIT, 1'b0, 4'd0, 0, 0, 0, 0, 0, 1'b0, 1'b1, -32768));
		rows.push_back(make_row(OP_DECODE, 1'b0, 4'd7, 0, 0, 0, 0, 0, 1'b0, 1'b1, 32767));
		rows.push_back(make_row(OP_DECODE, 1'b0, 4'd8, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_LOAD, 1'b1, 4'd0, -32768, -32768, 32767, -32768, -32768,
			1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 32767));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd8, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_LOAD, 1'b0, 4'd15, 32767, 32767, -32768, 0, 0, 1'b1,
			1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b0, 4'd7, 0, 0, 0, 0, 0, 1'b0, 1'b1, -32768));
		rows.push_back(make_row(OP_DECODE, 1'b0, 4'd15, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_LOAD, 1'b1, 4'd0, 512, -256, 1, 100, -100, 1'b0,
			1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd1, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd4, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd9, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd12, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_DECODE, 1'b1, 4'd6, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));
		rows.push_back(make_row(OP_IGNORED, 1'b0, 4'd15, -1, -1, -1, -1, -1, 1'b1,
			1'b0, 0));
		rows.push_back(make_row(OP_EMIT, 1'b1, 4'd0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0));
		rows.push_back(make_row(OP_EMIT, 1'b1, 4'd0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			drive_item(rows[i]);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 8)
				drive_item(random_row(2'($urandom_range(3)), 1'($urandom_range(1))));
			else
				send_block();
		end

		calm = 1'b0;
		item_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("ms_adpcm_sample_decoder regression: pass");
		else
			$display("ms_adpcm_sample_decoder regression: fail");
		$finish;
	end

endmodule

[ms_adpcm_sample_decoder.f]
hdl/msadpcm_pkg.sv
hdl/msadpcm_front.sv
hdl/msadpcm_queue.sv
hdl/msadpcm_back.sv
hdl/ms_adpcm_sample_decoder.sv
tb/testbench.sv
